[design/nsfx_pkg.sv]
`timescale 1ns / 1ps
// Shared types, register codes, reset values and arithmetic widths for the
// noise sfx voice mixer. No dependencies.

package nsfx_pkg;

    // Voice count default for the top-level parameter
    localparam int VOICE_COUNT_DEF = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_LOWPASS_COEFF     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EASE_RATE         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GUN_DECAY         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXPLOSION_DECAY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GUN_VOLUME        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EXPLOSION_VOLUME  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SILENCE_THRESHOLD = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_SEED        = 3'd7;

    // Register widths
    localparam int GAIN_W  = 15;   // Q0.15 gains and coefficients
    localparam int DECAY_W = 24;   // Q0.24 multipliers and threshold

    // Register reset values
    localparam logic [GAIN_W-1:0]  LOWPASS_COEFF_RST     = 15'd3942;
    localparam logic [GAIN_W-1:0]  EASE_RATE_RST         = 15'd655;
    localparam logic [DECAY_W-1:0] GUN_DECAY_RST         = 24'd16758204;
    localparam logic [DECAY_W-1:0] EXPLOSION_DECAY_RST   = 24'd16774290;
    localparam logic [GAIN_W-1:0]  GUN_VOLUME_RST        = 15'd4915;
    localparam logic [GAIN_W-1:0]  EXPLOSION_VOLUME_RST  = 15'd8192;
    localparam logic [DECAY_W-1:0] SILENCE_THRESHOLD_RST = 24'd167772;

    // Noise generator
    localparam logic [31:0] NOISE_SEED_RST = 32'h0123_4567;
    localparam logic [31:0] LCG_MUL        = 32'd1664525;
    localparam logic [31:0] LCG_INC        = 32'd1013904223;

    // Burner level, Q1.15 with full scale included
    localparam int               LEVEL_W     = 17;
    localparam logic [LEVEL_W-1:0] BURNER_FULL = 17'd32768;

    // Voice amplitude, Q0.24 with 1.0 included
    localparam int             AMP_W    = 25;
    localparam int             AMP_FRAC = 24;
    localparam logic [AMP_W-1:0] AMP_ONE = 25'h100_0000;

    localparam logic KIND_GUN       = 1'b0;
    localparam logic KIND_EXPLOSION = 1'b1;

    // Shared multiplier and accumulator
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 26;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 40;

    typedef struct packed {
        logic                kind;
        logic [AMP_W-1:0]    amp;
    } voice_word_t;

    typedef struct packed {
        logic signed [15:0]  music_sample;
        logic                burner_valid;
        logic [15:0]         burner_level;
        logic                fire_gun;
        logic                fire_explosion;
    } feed_t;

    typedef struct packed {
        logic signed [15:0]  mixed_sample;
        logic                clipped;
        logic [3:0]          busy_voices;
        logic                trigger_dropped;
    } result_t;

endpackage

[design/nsfx_stream_if.sv]
`timescale 1ns / 1ps
// Valid/ready stream channel carrying one payload beat per handshake.
// Payload type is set by the instantiating level; no other dependencies.

interface nsfx_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[design/noise_sfx_voice_mixer_core.sv]
`timescale 1ns / 1ps
// Top level of the noise sfx voice mixer: sequencer, registers, voice RAM.
// Depends on nsfx_pkg, nsfx_stream_if, nsfx_ram, nsfx_lcg and nsfx_mul.

// One input beat on feed gives exactly one result beat on result. Per sample the
// block applies the burner target, lets a gun trigger and then an explosion
// trigger claim the lowest free voice, eases the burner level, draws noise for
// the low-pass, forms the burner term, then walks the voices in index order.
// A sample takes longer with VOICE_COUNT, with each voice that sounds and with
// each voice that falls silent in that sample. Its length is set by the one
// shared multiplier, which forms three products in turn for a sounding voice,
// and by the registered read of the voice RAM that holds amplitude and kind.
// The result sits in an output register, so the next sample is taken while the
// previous result waits; the block stalls only if a second result is ready
// before the first is taken. Configuration writes take effect at once and are
// meant for idle periods; a write to noise_seed reloads the noise generator.

module noise_sfx_voice_mixer_core #(
    parameter int VOICE_COUNT = nsfx_pkg::VOICE_COUNT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    nsfx_stream_if.sink                      feed,
    nsfx_stream_if.source                    result,
    input  logic                             cfg_we,
    input  logic [nsfx_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nsfx_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int BUSY_W = $clog2(VOICE_COUNT + 1);
    localparam int WORD_W = $bits(nsfx_pkg::voice_word_t);
    localparam int MIX_W  = 26;
    localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(VOICE_COUNT - 1);

    // Sequencer states
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_GUN      = 4'd1;
    localparam logic [3:0] ST_EXP      = 4'd2;
    localparam logic [3:0] ST_EASE     = 4'd3;
    localparam logic [3:0] ST_EASE_ADD = 4'd4;
    localparam logic [3:0] ST_LP_ADD   = 4'd5;
    localparam logic [3:0] ST_BURN     = 4'd6;
    localparam logic [3:0] ST_BURN_ADD = 4'd7;
    localparam logic [3:0] ST_V_READ   = 4'd8;
    localparam logic [3:0] ST_V_CHECK  = 4'd9;
    localparam logic [3:0] ST_V_MUL1   = 4'd10;
    localparam logic [3:0] ST_V_MUL2   = 4'd11;
    localparam logic [3:0] ST_V_MUL3   = 4'd12;
    localparam logic [3:0] ST_V_WRITE  = 4'd13;
    localparam logic [3:0] ST_FINISH   = 4'd14;

    // Configuration registers
    logic [nsfx_pkg::GAIN_W-1:0]  lowpass_coeff_reg;
    logic [nsfx_pkg::GAIN_W-1:0]  ease_rate_reg;
    logic [nsfx_pkg::DECAY_W-1:0] gun_decay_reg;
    logic [nsfx_pkg::DECAY_W-1:0] explosion_decay_reg;
    logic [nsfx_pkg::GAIN_W-1:0]  gun_volume_reg;
    logic [nsfx_pkg::GAIN_W-1:0]  explosion_volume_reg;
    logic [nsfx_pkg::DECAY_W-1:0] silence_threshold_reg;

    // Control and model state
    logic [3:0]                        state_reg, state_next;
    logic [VIDX_W-1:0]                 v_reg, v_next;
    logic [VOICE_COUNT-1:0]            active_reg, active_next;
    logic [BUSY_W-1:0]                 busy_reg, busy_next;
    logic [nsfx_pkg::LEVEL_W-1:0]      target_reg, target_next;
    logic [nsfx_pkg::LEVEL_W-1:0]      level_reg, level_next;
    logic signed [15:0]                lp_reg, lp_next;
    logic                              out_valid_reg, out_valid_next;

    // Per-sample working registers
    logic signed [15:0]                music_reg, music_next;
    logic                              fire_gun_reg, fire_gun_next;
    logic                              fire_exp_reg, fire_exp_next;
    logic                              dropped_reg, dropped_next;
    logic signed [nsfx_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [nsfx_pkg::AMP_W-1:0]        amp_reg, amp_next;
    logic                              kind_reg, kind_next;
    nsfx_pkg::result_t                 out_reg, out_next;

    // Datapath links
    logic [31:0]                          noise_state;
    logic                                 lcg_step;
    logic                                 lcg_load;
    logic signed [15:0]                   noise_val;
    logic signed [nsfx_pkg::MUL_A_W-1:0]  mul_a;
    logic signed [nsfx_pkg::MUL_B_W-1:0]  mul_b;
    logic signed [nsfx_pkg::MUL_P_W-1:0]  mul_p;
    logic                                 ram_we;
    logic [VIDX_W-1:0]                    ram_waddr;
    nsfx_pkg::voice_word_t                ram_wdata;
    logic                                 ram_re;
    logic [WORD_W-1:0]                    ram_rdata_raw;
    nsfx_pkg::voice_word_t                ram_rdata;

    logic                                 free_found;
    logic [VIDX_W-1:0]                    free_idx;
    logic signed [17:0]                   ease_diff;
    logic signed [16:0]                   lp_diff;
    logic signed [MIX_W-1:0]              mix_wide;
    logic                                 advance_last;

    assign noise_val     = {~noise_state[31], noise_state[30:16]};
    assign ram_rdata     = nsfx_pkg::voice_word_t'(ram_rdata_raw);
    assign ease_diff     = $signed({1'b0, target_reg}) - $signed({1'b0, level_reg});
    assign lp_diff       = 17'(noise_val) - 17'(lp_reg);
    assign mix_wide      = MIX_W'(music_reg) + MIX_W'(acc_reg >>> 15);
    assign advance_last  = (v_reg == LAST_VOICE);
    assign lcg_load      = cfg_we && (cfg_index == nsfx_pkg::REG_NOISE_SEED);

    assign feed.ready    = (state_reg == ST_IDLE);
    assign result.valid  = out_valid_reg;
    assign result.payload = out_reg;

    // Lowest free voice
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = VOICE_COUNT - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = VIDX_W'(i);
            end
        end
    end

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_EASE:
            begin
                mul_a = nsfx_pkg::MUL_A_W'(ease_diff);
                mul_b = $signed(nsfx_pkg::MUL_B_W'(ease_rate_reg));
            end
            ST_EASE_ADD:
            begin
                mul_a = nsfx_pkg::MUL_A_W'(lp_diff);
                mul_b = $signed(nsfx_pkg::MUL_B_W'(lowpass_coeff_reg));
            end
            ST_BURN:
            begin
                mul_a = nsfx_pkg::MUL_A_W'(lp_reg);
                mul_b = $signed(nsfx_pkg::MUL_B_W'(level_reg));
            end
            ST_V_MUL1:
            begin
                mul_a = nsfx_pkg::MUL_A_W'(noise_val);
                mul_b = $signed(nsfx_pkg::MUL_B_W'(
                            kind_reg ? explosion_volume_reg : gun_volume_reg));
            end
            ST_V_MUL2:
            begin
                // n * volume fits in 31 bits signed
                mul_a = mul_p[nsfx_pkg::MUL_A_W-1:0];
                mul_b = $signed(nsfx_pkg::MUL_B_W'(amp_reg));
            end
            ST_V_MUL3:
            begin
                mul_a = $signed(nsfx_pkg::MUL_A_W'(amp_reg));
                mul_b = $signed(nsfx_pkg::MUL_B_W'(
                            kind_reg ? explosion_decay_reg : gun_decay_reg));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        v_next         = v_reg;
        active_next    = active_reg;
        busy_next      = busy_reg;
        target_next    = target_reg;
        level_next     = level_reg;
        lp_next        = lp_reg;
        music_next     = music_reg;
        fire_gun_next  = fire_gun_reg;
        fire_exp_next  = fire_exp_reg;
        dropped_next   = dropped_reg;
        acc_next       = acc_reg;
        amp_next       = amp_reg;
        kind_next      = kind_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result.ready;
        lcg_step       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = free_idx;
        ram_wdata      = '{kind: nsfx_pkg::KIND_GUN, amp: nsfx_pkg::AMP_ONE};
        ram_re         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (feed.valid)
                begin
                    // Take the beat; a new burner target saturates at full scale
                    music_next    = feed.payload.music_sample;
                    fire_gun_next = feed.payload.fire_gun;
                    fire_exp_next = feed.payload.fire_explosion;
                    dropped_next  = 1'b0;
                    if (feed.payload.burner_valid)
                    begin
                        if (feed.payload.burner_level > 16'(nsfx_pkg::BURNER_FULL))
                        begin
                            target_next = nsfx_pkg::BURNER_FULL;
                        end
                        else
                        begin
                            target_next = nsfx_pkg::LEVEL_W'(feed.payload.burner_level);
                        end
                    end
                    state_next = ST_GUN;
                end
            end
            ST_GUN:
            begin
                if (fire_gun_reg)
                begin
                    if (free_found)
                    begin
                        active_next[free_idx] = 1'b1;
                        busy_next             = busy_reg + 1'b1;
                        ram_we                = 1'b1;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                end
                state_next = ST_EXP;
            end
            ST_EXP:
            begin
                if (fire_exp_reg)
                begin
                    if (free_found)
                    begin
                        active_next[free_idx] = 1'b1;
                        busy_next             = busy_reg + 1'b1;
                        ram_we                = 1'b1;
                        ram_wdata.kind        = nsfx_pkg::KIND_EXPLOSION;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                end
                state_next = ST_EASE;
            end
            ST_EASE:
            begin
                // Ease product issues now; draw the low-pass noise alongside
                lcg_step   = 1'b1;
                v_next     = '0;
                state_next = ST_EASE_ADD;
            end
            ST_EASE_ADD:
            begin
                level_next = nsfx_pkg::LEVEL_W'(
                                 nsfx_pkg::MUL_P_W'($signed({1'b0, level_reg}))
                                 + (mul_p >>> 15));
                state_next = ST_LP_ADD;
            end
            ST_LP_ADD:
            begin
                lp_next    = 16'(nsfx_pkg::MUL_P_W'(lp_reg) + (mul_p >>> 15));
                state_next = ST_BURN;
            end
            ST_BURN:
            begin
                state_next = ST_BURN_ADD;
            end
            ST_BURN_ADD:
            begin
                acc_next   = nsfx_pkg::ACC_W'(mul_p);
                state_next = ST_V_READ;
            end
            ST_V_READ:
            begin
                if (active_reg[v_reg])
                begin
                    ram_re     = 1'b1;
                    state_next = ST_V_CHECK;
                end
                else if (advance_last)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    v_next = v_reg + 1'b1;
                end
            end
            ST_V_CHECK:
            begin
                if (ram_rdata.amp < nsfx_pkg::AMP_W'(silence_threshold_reg))
                begin
                    // Silent: free the voice, no noise draw
                    active_next[v_reg] = 1'b0;
                    busy_next          = busy_reg - 1'b1;
                    if (advance_last)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        v_next     = v_reg + 1'b1;
                        state_next = ST_V_READ;
                    end
                end
                else
                begin
                    lcg_step   = 1'b1;
                    amp_next   = ram_rdata.amp;
                    kind_next  = ram_rdata.kind;
                    state_next = ST_V_MUL1;
                end
            end
            ST_V_MUL1:
            begin
                state_next = ST_V_MUL2;
            end
            ST_V_MUL2:
            begin
                state_next = ST_V_MUL3;
            end
            ST_V_MUL3:
            begin
                acc_next   = acc_reg + nsfx_pkg::ACC_W'(mul_p >>> nsfx_pkg::AMP_FRAC);
                state_next = ST_V_WRITE;
            end
            ST_V_WRITE:
            begin
                // Write back the decayed amplitude
                ram_we         = 1'b1;
                ram_waddr      = v_reg;
                ram_wdata.kind = kind_reg;
                ram_wdata.amp  = mul_p[nsfx_pkg::AMP_FRAC + nsfx_pkg::AMP_W - 1:
                                       nsfx_pkg::AMP_FRAC];
                if (advance_last)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    v_next     = v_reg + 1'b1;
                    state_next = ST_V_READ;
                end
            end
            ST_FINISH:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next          = 1'b1;
                    out_next.clipped        = 1'b0;
                    out_next.mixed_sample   = 16'(mix_wide);
                    if (mix_wide > MIX_W'(32767))
                    begin
                        out_next.mixed_sample = 16'sh7fff;
                        out_next.clipped      = 1'b1;
                    end
                    else if (mix_wide < -MIX_W'(32768))
                    begin
                        out_next.mixed_sample = 16'sh8000;
                        out_next.clipped      = 1'b1;
                    end
                    out_next.busy_voices     = 4'(busy_reg);
                    out_next.trigger_dropped = dropped_reg;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control, model state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= ST_IDLE;
            active_reg            <= '0;
            busy_reg              <= '0;
            target_reg            <= '0;
            level_reg             <= '0;
            lp_reg                <= '0;
            out_valid_reg         <= 1'b0;
            lowpass_coeff_reg     <= nsfx_pkg::LOWPASS_COEFF_RST;
            ease_rate_reg         <= nsfx_pkg::EASE_RATE_RST;
            gun_decay_reg         <= nsfx_pkg::GUN_DECAY_RST;
            explosion_decay_reg   <= nsfx_pkg::EXPLOSION_DECAY_RST;
            gun_volume_reg        <= nsfx_pkg::GUN_VOLUME_RST;
            explosion_volume_reg  <= nsfx_pkg::EXPLOSION_VOLUME_RST;
            silence_threshold_reg <= nsfx_pkg::SILENCE_THRESHOLD_RST;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            busy_reg      <= busy_next;
            target_reg    <= target_next;
            level_reg     <= level_next;
            lp_reg        <= lp_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    nsfx_pkg::REG_LOWPASS_COEFF:
                        lowpass_coeff_reg <= cfg_data[nsfx_pkg::GAIN_W-1:0];
                    nsfx_pkg::REG_EASE_RATE:
                        ease_rate_reg <= cfg_data[nsfx_pkg::GAIN_W-1:0];
                    nsfx_pkg::REG_GUN_DECAY:
                        gun_decay_reg <= cfg_data[nsfx_pkg::DECAY_W-1:0];
                    nsfx_pkg::REG_EXPLOSION_DECAY:
                        explosion_decay_reg <= cfg_data[nsfx_pkg::DECAY_W-1:0];
                    nsfx_pkg::REG_GUN_VOLUME:
                        gun_volume_reg <= cfg_data[nsfx_pkg::GAIN_W-1:0];
                    nsfx_pkg::REG_EXPLOSION_VOLUME:
                        explosion_volume_reg <= cfg_data[nsfx_pkg::GAIN_W-1:0];
                    nsfx_pkg::REG_SILENCE_THRESHOLD:
                        silence_threshold_reg <= cfg_data[nsfx_pkg::DECAY_W-1:0];
                    default:
                    begin
                        // noise seed loads the generator directly
                    end
                endcase
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        v_reg        <= v_next;
        music_reg    <= music_next;
        fire_gun_reg <= fire_gun_next;
        fire_exp_reg <= fire_exp_next;
        dropped_reg  <= dropped_next;
        acc_reg      <= acc_next;
        amp_reg      <= amp_next;
        kind_reg     <= kind_next;
        out_reg      <= out_next;
    end

    nsfx_lcg u_lcg (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (lcg_step),
        .load  (lcg_load),
        .seed  (cfg_data),
        .state (noise_state)
    );

    nsfx_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    nsfx_ram #(
        .WIDTH  (WORD_W),
        .DEPTH  (VOICE_COUNT),
        .ADDR_W (VIDX_W)
    ) u_voice_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (v_reg),
        .rdata (ram_rdata_raw)
    );

endmodule

[design/nsfx_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.

module nsfx_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/nsfx_lcg.sv]
`timescale 1ns / 1ps
// 32-bit linear congruential noise generator with seed load.
// Depends on nsfx_pkg for the LCG constants and reset seed.

module nsfx_lcg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic        load,
    input  logic [31:0] seed,
    output logic [31:0] state
);

    logic [31:0] state_reg;
    logic [31:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        if (load)
        begin
            state_next = seed;
        end
        else if (step)
        begin
            state_next = 32'(state_reg * nsfx_pkg::LCG_MUL + nsfx_pkg::LCG_INC);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nsfx_pkg::NOISE_SEED_RST;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

[design/nsfx_mul.sv]
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
// Depends on nsfx_pkg for operand and product widths.

module nsfx_mul (
    input  logic                               clk,
    input  logic signed [nsfx_pkg::MUL_A_W-1:0] a,
    input  logic signed [nsfx_pkg::MUL_B_W-1:0] b,
    output logic signed [nsfx_pkg::MUL_P_W-1:0] p
);

    logic signed [nsfx_pkg::MUL_P_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= nsfx_pkg::MUL_P_W'(a) * nsfx_pkg::MUL_P_W'(b);
    end

    assign p = p_reg;

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for noise_sfx_voice_mixer_core: stream beats in, one
// mixed sample beat out. Depends on nsfx_pkg, nsfx_stream_if and the core.

module tb;

    localparam int NUM_VOICES    = nsfx_pkg::VOICE_COUNT_DEF;
    // The slowest sample has all eight voices sounding; settle beyond it.
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 1_000_000;
    // Long back-pressure episode: starts once this many results were taken.
    localparam int LONG_HOLD_AT     = 500;
    localparam int LONG_HOLD_CYCLES = 400;

    // Fields of a directed row that are typed in rather than predicted
    localparam logic [3:0] PIN_NONE = 4'b0000;
    localparam logic [3:0] PIN_MIX  = 4'b0001;
    localparam logic [3:0] PIN_CLIP = 4'b0010;
    localparam logic [3:0] PIN_BUSY = 4'b0100;
    localparam logic [3:0] PIN_DROP = 4'b1000;
    localparam logic [3:0] PIN_ALL  = 4'b1111;

    typedef struct {
        nsfx_pkg::feed_t   stim;
        logic [3:0]        pin;
        nsfx_pkg::result_t fixed;
    } stim_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [nsfx_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [nsfx_pkg::CFG_DATA_W-1:0] cfg_data;

    nsfx_stream_if #(.payload_t(nsfx_pkg::feed_t))   feed_ch ();
    nsfx_stream_if #(.payload_t(nsfx_pkg::result_t)) result_ch ();

    noise_sfx_voice_mixer_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .feed      (feed_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Mixer model: own copy of registers and state, advanced once per
    // accepted feed beat and once per register write.
    // ------------------------------------------------------------------
    longint      k_lowpass, k_ease, k_gun_decay, k_expl_decay;
    longint      k_gun_vol, k_expl_vol, k_silence;
    logic [31:0] lcg_state;
    longint      burner_goal, burner_now, lp_acc;
    logic        voice_on   [NUM_VOICES];
    longint      voice_amp  [NUM_VOICES];
    logic        voice_kind [NUM_VOICES];

    // Expected mixed-sample beats, oldest first
    nsfx_pkg::result_t expected_mix [$];
    stim_row_t         directed_rows [$];

    // Bench control and bookkeeping
    bit          src_gaps;
    bit          sink_stalls;
    int unsigned results_seen;
    int unsigned samples_sent;
    int unsigned mismatches;
    int unsigned clip_count;
    int unsigned drop_count;
    int unsigned busy_peak;

    // Advance the noise generator and return the draw in Q1.15, [-1, 1).
    function automatic longint next_noise();
        lcg_state = lcg_state * nsfx_pkg::LCG_MUL + nsfx_pkg::LCG_INC;
        return longint'(lcg_state[31:16]) - 32768;
    endfunction

    // Claim the lowest idle voice at full amplitude; report whether one was free.
    function automatic bit take_free_voice(input logic kind);
        for (int i = 0; i < NUM_VOICES; i++)
        begin
            if (!voice_on[i])
            begin
                voice_on[i]   = 1'b1;
                voice_amp[i]  = longint'(nsfx_pkg::AMP_ONE);
                voice_kind[i] = kind;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic nsfx_pkg::result_t mix_next_sample(input nsfx_pkg::feed_t x);
        nsfx_pkg::result_t r;
        longint  acc, mix, vol, decay, n;
        int      busy;
        logic    dropped;
        dropped = 1'b0;
        busy    = 0;
        if (x.burner_valid)
            burner_goal = (x.burner_level > nsfx_pkg::BURNER_FULL)
                          ? longint'(nsfx_pkg::BURNER_FULL)
                          : longint'(x.burner_level);
        // Gun claims first, then the explosion takes the next free slot.
        if (x.fire_gun)
            if (!take_free_voice(nsfx_pkg::KIND_GUN))
                dropped = 1'b1;
        if (x.fire_explosion)
            if (!take_free_voice(nsfx_pkg::KIND_EXPLOSION))
                dropped = 1'b1;

        burner_now += ((burner_goal - burner_now) * k_ease) >>> 15;
        n = next_noise();
        lp_acc += ((n - lp_acc) * k_lowpass) >>> 15;
        acc = lp_acc * burner_now;

        for (int i = 0; i < NUM_VOICES; i++)
        begin
            if (voice_on[i])
            begin
                // A quiet voice is released before it draws any noise.
                if (voice_amp[i] < k_silence)
                    voice_on[i] = 1'b0;
                else
                begin
                    vol   = (voice_kind[i] == nsfx_pkg::KIND_EXPLOSION)
                            ? k_expl_vol : k_gun_vol;
                    decay = (voice_kind[i] == nsfx_pkg::KIND_EXPLOSION)
                            ? k_expl_decay : k_gun_decay;
                    n = next_noise();
                    acc += (n * vol * voice_amp[i]) >>> 24;
                    voice_amp[i] = (voice_amp[i] * decay) >>> 24;
                end
            end
            if (voice_on[i])
                busy++;
        end

        mix = longint'(x.music_sample) + (acc >>> 15);
        r.clipped = 1'b0;
        if (mix > 32767)
        begin
            mix = 32767;
            r.clipped = 1'b1;
        end
        else if (mix < -32768)
        begin
            mix = -32768;
            r.clipped = 1'b1;
        end
        r.mixed_sample    = mix[15:0];
        r.busy_voices     = busy[3:0];
        r.trigger_dropped = dropped;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one feed beat, hold it until taken, then queue its prediction.
    // Pinned fields of a directed row override the model's answer.
    task automatic send_sample(input nsfx_pkg::feed_t x, input logic [3:0] pin,
                               input nsfx_pkg::result_t fixed);
        nsfx_pkg::result_t want;
        if (src_gaps && $urandom_range(0, 3) == 0)
        begin
            feed_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        feed_ch.valid   <= 1'b1;
        feed_ch.payload <= x;
        @(posedge clk);
        while (!feed_ch.ready)
            @(posedge clk);
        want = mix_next_sample(x);
        if ((pin & PIN_MIX) != 0)
            want.mixed_sample = fixed.mixed_sample;
        if ((pin & PIN_CLIP) != 0)
            want.clipped = fixed.clipped;
        if ((pin & PIN_BUSY) != 0)
            want.busy_voices = fixed.busy_voices;
        if ((pin & PIN_DROP) != 0)
            want.trigger_dropped = fixed.trigger_dropped;
        expected_mix.push_back(want);
        samples_sent++;
    endtask

    // Directed row; a pinned mix is the music itself (burner and voices silent).
    function automatic void add_row(input logic [15:0] music, input logic bv,
                                    input logic [15:0] lvl, input logic fg,
                                    input logic fe, input logic [3:0] pin,
                                    input logic [3:0] busy, input logic drop);
        stim_row_t row;
        row.stim.music_sample      = music;
        row.stim.burner_valid      = bv;
        row.stim.burner_level      = lvl;
        row.stim.fire_gun          = fg;
        row.stim.fire_explosion    = fe;
        row.pin                    = pin;
        row.fixed.mixed_sample     = music;
        row.fixed.clipped          = 1'b0;
        row.fixed.busy_voices      = busy;
        row.fixed.trigger_dropped  = drop;
        directed_rows.push_back(row);
    endfunction

    // One register write; mirror it into the model with the register's mask.
    task automatic write_reg(input logic [nsfx_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            nsfx_pkg::REG_LOWPASS_COEFF:     k_lowpass    = val[nsfx_pkg::GAIN_W-1:0];
            nsfx_pkg::REG_EASE_RATE:         k_ease       = val[nsfx_pkg::GAIN_W-1:0];
            nsfx_pkg::REG_GUN_DECAY:         k_gun_decay  = val[nsfx_pkg::DECAY_W-1:0];
            nsfx_pkg::REG_EXPLOSION_DECAY:   k_expl_decay = val[nsfx_pkg::DECAY_W-1:0];
            nsfx_pkg::REG_GUN_VOLUME:        k_gun_vol    = val[nsfx_pkg::GAIN_W-1:0];
            nsfx_pkg::REG_EXPLOSION_VOLUME:  k_expl_vol   = val[nsfx_pkg::GAIN_W-1:0];
            nsfx_pkg::REG_SILENCE_THRESHOLD: k_silence    = val[nsfx_pkg::DECAY_W-1:0];
            nsfx_pkg::REG_NOISE_SEED:        lcg_state    = val;
            default:                         ;
        endcase
    endtask

    // Write the whole register set in index order, then release the port.
    task automatic program_regs(input logic [31:0] lp, input logic [31:0] ease,
                                input logic [31:0] gdec, input logic [31:0] edec,
                                input logic [31:0] gvol, input logic [31:0] evol,
                                input logic [31:0] thr, input logic [31:0] seed);
        write_reg(nsfx_pkg::REG_LOWPASS_COEFF, lp);
        write_reg(nsfx_pkg::REG_EASE_RATE, ease);
        write_reg(nsfx_pkg::REG_GUN_DECAY, gdec);
        write_reg(nsfx_pkg::REG_EXPLOSION_DECAY, edec);
        write_reg(nsfx_pkg::REG_GUN_VOLUME, gvol);
        write_reg(nsfx_pkg::REG_EXPLOSION_VOLUME, evol);
        write_reg(nsfx_pkg::REG_SILENCE_THRESHOLD, thr);
        write_reg(nsfx_pkg::REG_NOISE_SEED, seed);
        cfg_we <= 1'b0;
    endtask

    // Hold until every queued sample has come back, then let the core settle.
    task automatic wait_drained();
        while (expected_mix.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random samples: music mostly uniform with some rail values, occasional
    // burner updates (often above full), and frequent triggers so voices churn.
    task automatic run_phase(input int count);
        nsfx_pkg::feed_t   x;
        logic [31:0]       r;
        nsfx_pkg::result_t none;
        none = '0;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom;
            x.music_sample = r[15:0];
            if ($urandom_range(0, 15) == 0)
                x.music_sample = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            r = $urandom;
            x.burner_valid   = ($urandom_range(0, 9) == 0);
            x.burner_level   = ($urandom_range(0, 3) == 0) ? 16'h8000 : r[15:0];
            x.fire_gun       = ($urandom_range(0, 5) == 0);
            x.fire_explosion = ($urandom_range(0, 7) == 0);
            send_sample(x, PIN_NONE, none);
        end
        feed_ch.valid <= 1'b0;
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Result sink: random short stalls, plus one long hold-off so the output
    // register fills and the core pushes back on the feed.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned hold_left;
        bit          long_hold_done;
        hold_left      = 0;
        long_hold_done = 1'b0;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (!long_hold_done && results_seen >= LONG_HOLD_AT)
            begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD_CYCLES;
                result_ch.ready <= 1'b0;
            end
            else if (sink_stalls && $urandom_range(0, 5) == 0)
            begin
                hold_left = $urandom_range(0, 3);
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Checker: compare each result beat against the oldest prediction.
    // ------------------------------------------------------------------
    task automatic check_field(input string what, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        nsfx_pkg::result_t want;
        nsfx_pkg::result_t got;
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            got = result_ch.payload;
            results_seen <= results_seen + 1;
            if (expected_mix.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: result beat with nothing pending, expected none, got %0d",
                         $time, got.mixed_sample);
            end
            else
            begin
                want = expected_mix.pop_front();
                check_field("mixed_sample", want.mixed_sample, got.mixed_sample);
                check_field("clipped", want.clipped, got.clipped);
                check_field("busy_voices", want.busy_voices, got.busy_voices);
                check_field("trigger_dropped", want.trigger_dropped, got.trigger_dropped);
                if (want.clipped)
                    clip_count++;
                if (want.trigger_dropped)
                    drop_count++;
                if (want.busy_voices > busy_peak)
                    busy_peak = want.busy_voices;
            end
        end
    end

    // Hard stop if the whole run overruns the cycle limit.
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t ns: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
        $display("tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        feed_ch.valid   <= 1'b0;
        feed_ch.payload <= '0;
        src_gaps     = 1'b1;
        sink_stalls  = 1'b1;
        results_seen = 0;
        samples_sent = 0;
        mismatches   = 0;
        clip_count   = 0;
        drop_count   = 0;
        busy_peak    = 0;

        // Model state after reset
        k_lowpass    = nsfx_pkg::LOWPASS_COEFF_RST;
        k_ease       = nsfx_pkg::EASE_RATE_RST;
        k_gun_decay  = nsfx_pkg::GUN_DECAY_RST;
        k_expl_decay = nsfx_pkg::EXPLOSION_DECAY_RST;
        k_gun_vol    = nsfx_pkg::GUN_VOLUME_RST;
        k_expl_vol   = nsfx_pkg::EXPLOSION_VOLUME_RST;
        k_silence    = nsfx_pkg::SILENCE_THRESHOLD_RST;
        lcg_state    = nsfx_pkg::NOISE_SEED_RST;
        burner_goal  = 0;
        burner_now   = 0;
        lp_acc       = 0;
        for (int i = 0; i < NUM_VOICES; i++)
        begin
            voice_on[i]   = 1'b0;
            voice_amp[i]  = 0;
            voice_kind[i] = nsfx_pkg::KIND_GUN;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset register values.
        // Fresh out of reset the burner is silent, so the mix is the music.
        add_row(16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0, PIN_ALL, 4'd0, 1'b0);
        add_row(16'h7fff, 1'b0, 16'h0000, 1'b0, 1'b0, PIN_ALL, 4'd0, 1'b0);
        add_row(16'h8000, 1'b0, 16'h0000, 1'b0, 1'b0, PIN_ALL, 4'd0, 1'b0);
        // Burner targets above full saturate; then exactly full, then one above.
        add_row(16'h0001, 1'b1, 16'hffff, 1'b0, 1'b0, PIN_NONE, 4'd0, 1'b0);
        add_row(16'hffff, 1'b1, 16'h8000, 1'b0, 1'b0, PIN_NONE, 4'd0, 1'b0);
        add_row(16'h5555, 1'b1, 16'h8001, 1'b0, 1'b0, PIN_NONE, 4'd0, 1'b0);
        // Fill all eight voices: gun and explosion together, then singly.
        add_row(16'h0000, 1'b0, 16'h0000, 1'b1, 1'b1, PIN_BUSY | PIN_DROP, 4'd2, 1'b0);
        add_row(16'haaaa, 1'b0, 16'h0000, 1'b1, 1'b1, PIN_BUSY | PIN_DROP, 4'd4, 1'b0);
        add_row(16'h7fff, 1'b0, 16'h0000, 1'b1, 1'b1, PIN_BUSY | PIN_DROP, 4'd6, 1'b0);
        add_row(16'h8000, 1'b0, 16'h0000, 1'b1, 1'b0, PIN_BUSY | PIN_DROP, 4'd7, 1'b0);
        add_row(16'h1234, 1'b0, 16'h0000, 1'b0, 1'b1, PIN_BUSY | PIN_DROP, 4'd8, 1'b0);
        // No voice left: every trigger is dropped and flagged.
        add_row(16'h0000, 1'b0, 16'h0000, 1'b1, 1'b0, PIN_BUSY | PIN_DROP, 4'd8, 1'b1);
        add_row(16'h7fff, 1'b0, 16'h0000, 1'b0, 1'b1, PIN_BUSY | PIN_DROP, 4'd8, 1'b1);
        add_row(16'h8000, 1'b1, 16'h0000, 1'b1, 1'b1, PIN_BUSY | PIN_DROP, 4'd8, 1'b1);
        // Burner winding down, music on the rails.
        add_row(16'h7fff, 1'b0, 16'h0000, 1'b0, 1'b0, PIN_NONE, 4'd0, 1'b0);
        add_row(16'h8000, 1'b1, 16'h7fff, 1'b0, 1'b0, PIN_NONE, 4'd0, 1'b0);
        add_row(16'hc3a5, 1'b1, 16'h0001, 1'b0, 1'b0, PIN_NONE, 4'd0, 1'b0);
        add_row(16'h3c5a, 1'b0, 16'h0000, 1'b0, 1'b0, PIN_NONE, 4'd0, 1'b0);
        foreach (directed_rows[k])
            send_sample(directed_rows[k].stim, directed_rows[k].pin, directed_rows[k].fixed);
        feed_ch.valid <= 1'b0;
        wait_drained();

        // Every register at its top, with all-ones data to exercise masking:
        // voices sound for only a couple of samples.
        program_regs(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                     32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        run_phase(300);

        // Every register at zero: no easing, no filtering, voices never free.
        program_regs('0, '0, '0, '0, '0, '0, '0, '0);
        run_phase(250);

        // Random settings with junk above each register's width; decays short
        // enough that voices recycle.
        repeat (3)
        begin
            program_regs($urandom_range(0, 32767) | ($urandom << nsfx_pkg::GAIN_W),
                         $urandom_range(0, 32767) | ($urandom << nsfx_pkg::GAIN_W),
                         ((1 << nsfx_pkg::AMP_FRAC) - $urandom_range(2000, 400000))
                             | ($urandom << nsfx_pkg::DECAY_W),
                         ((1 << nsfx_pkg::AMP_FRAC) - $urandom_range(500, 200000))
                             | ($urandom << nsfx_pkg::DECAY_W),
                         $urandom_range(0, 32767) | ($urandom << nsfx_pkg::GAIN_W),
                         $urandom_range(0, 32767) | ($urandom << nsfx_pkg::GAIN_W),
                         $urandom_range(1 << 16, 1 << 23) | ($urandom << nsfx_pkg::DECAY_W),
                         $urandom);
            run_phase(400);
        end

        // Back to reset values, both sides running flat out.
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        program_regs(nsfx_pkg::LOWPASS_COEFF_RST, nsfx_pkg::EASE_RATE_RST,
                     nsfx_pkg::GUN_DECAY_RST, nsfx_pkg::EXPLOSION_DECAY_RST,
                     nsfx_pkg::GUN_VOLUME_RST, nsfx_pkg::EXPLOSION_VOLUME_RST,
                     nsfx_pkg::SILENCE_THRESHOLD_RST, nsfx_pkg::NOISE_SEED_RST);
        run_phase(300);

        $display("Mixed %0d samples over 6 register settings with stalls and back-pressure.",
                 samples_sent);
        $display("Saw %0d clipped samples, %0d dropped triggers, up to %0d busy voices.",
                 clip_count, drop_count, busy_peak);
        if (mismatches == 0 && expected_mix.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

[sim.f]
design/nsfx_pkg.sv
design/nsfx_stream_if.sv
design/nsfx_ram.sv
design/nsfx_lcg.sv
design/nsfx_mul.sv
design/noise_sfx_voice_mixer_core.sv
tb/sv/tb.sv
